// File: sv/enrl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enrl_pkg
// Shared sizes, constants and types of the notification rate limiter.
// ----------------------------------------------------------------------------
package enrl_pkg;

   localparam int ENTRIES    = 16;
   localparam int NAME_BYTES = 128;

   localparam int SLOT_W  = $clog2(ENTRIES);
   localparam int LEN_W   = $clog2(NAME_BYTES);
   localparam int NADDR_W = SLOT_W + LEN_W;

   localparam logic [31:0]       INTERVAL_RESET = 32'd60000;
   localparam logic [LEN_W-1:0]  LEN_MAX        = LEN_W'(NAME_BYTES - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST      = SLOT_W'(ENTRIES - 1);

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_MATCH   = 11'b000_0000_0010,
      S_RD      = 11'b000_0000_0100,
      S_CMP     = 11'b000_0000_1000,
      S_ELAPSED = 11'b000_0001_0000,
      S_CHECK   = 11'b000_0010_0000,
      S_OLDEST  = 11'b000_0100_0000,
      S_COPY_RD = 11'b000_1000_0000,
      S_COPY_WR = 11'b001_0000_0000,
      S_META    = 11'b010_0000_0000,
      S_DONE    = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  rd_slot;
      logic [NADDR_W-1:0] name_raddr;
      logic               name_we;
      logic [NADDR_W-1:0] name_waddr;
      logic [7:0]         name_wdata;
      logic               meta_we;
      logic [SLOT_W-1:0]  meta_slot;
      logic [31:0]        meta_addr;
      logic [31:0]        meta_stamp;
      logic [LEN_W-1:0]   meta_len;
   } store_ctl_type;

   typedef struct packed {
      logic [31:0]      addr;
      logic [31:0]      stamp;
      logic [LEN_W-1:0] len;
      logic [7:0]       name_byte;
   } store_rd_type;

   typedef struct packed {
      logic [31:0] diff;
      logic        lt;
      logic        eq;
   } alu_out_type;

   // slot number as reported, low four bits
   function automatic logic [3:0] slot_code(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W+3:0] ext;
      ext = {4'b0000, slot};
      return ext[3:0];
   endfunction

endpackage
`default_nettype wire

// File: sv/enrl_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enrl_alu
// Shared 32-bit subtractor: difference, borrow (less than) and equality.
// ----------------------------------------------------------------------------
module enrl_alu
   import enrl_pkg::*;
(
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output alu_out_type      res
);

   logic [32:0] wide;

   always_comb begin
      wide     = {1'b0, op_a} - {1'b0, op_b};
      res.diff = wide[31:0];
      res.lt   = wide[32];
      res.eq   = (wide[31:0] == 32'd0);
   end

endmodule
`default_nettype wire

// File: sv/enrl_name_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enrl_name_buf
// Buffer for the name being received, one write and one registered read port.
// ----------------------------------------------------------------------------
module enrl_name_buf
   import enrl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [LEN_W-1:0] waddr,
   input  wire logic [7:0]       wdata,
   input  wire logic [LEN_W-1:0] raddr,
   output logic      [7:0]       rdata
);

   logic [7:0] mem [NAME_BYTES];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// File: sv/enrl_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enrl_store
// Entry store: name memory plus per-slot address, timestamp and name length.
// ----------------------------------------------------------------------------
module enrl_store
   import enrl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire store_ctl_type ctl,
   output store_rd_type       rd
);

   logic [7:0]       names [ENTRIES * (2 ** LEN_W)];
   logic [31:0]      addr_ff  [ENTRIES];
   logic [31:0]      stamp_ff [ENTRIES];
   logic [LEN_W-1:0] len_ff   [ENTRIES];
   logic [7:0]       byte_ff;

   // name bytes beyond a slot's length are never read, so the memory needs no clear
   always_ff @(posedge clock) begin
      if (ctl.name_we) begin
         names[ctl.name_waddr] <= ctl.name_wdata;
      end
      byte_ff <= names[ctl.name_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            addr_ff[i]  <= '0;
            stamp_ff[i] <= '0;
            len_ff[i]   <= '0;
         end
      end else if (ctl.meta_we) begin
         addr_ff[ctl.meta_slot]  <= ctl.meta_addr;
         stamp_ff[ctl.meta_slot] <= ctl.meta_stamp;
         len_ff[ctl.meta_slot]   <= ctl.meta_len;
      end
   end

   always_comb begin
      rd.addr      = addr_ff[ctl.rd_slot];
      rd.stamp     = stamp_ff[ctl.rd_slot];
      rd.len       = len_ff[ctl.rd_slot];
      rd.name_byte = byte_ff;
   end

endmodule
`default_nettype wire

// File: sv/event_notify_rate_limiter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// event_notify_rate_limiter
// Per (name, address) notification rate limiter with oldest-entry replacement.
// ----------------------------------------------------------------------------
// A name arrives on the req_ channel one character per item; a zero character
// ends it and carries req_client_addr and req_now_ms. Character items give no
// result. The ending item gives one item on rsp_.
// The ending item is worked by a sequencer around one shared subtractor:
//   a header check per slot, plus a name compare (read, then compare each
//   byte) on slots whose address and length agree; a hit then computes the
//   elapsed time and checks it. A miss searches all slots for the oldest,
//   copies the name into it (read, then write each character) and writes
//   the slot. The result is then loaded into the output register.
// req_stall is high from the ending item until its result is loaded.
// A stalled result is held in the output register; the next name may stream in
// meanwhile, but the next ending item's result waits until that one is taken.
// Synchronous reset clears all entries, the name length and the flags, and
// sets interval_ms to 60000. csr_ready is tied high; write only while idle.
// ----------------------------------------------------------------------------
module event_notify_rate_limiter
   import enrl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_name_char,
   input  wire logic [31:0] req_client_addr,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_notify,
   output logic             rsp_was_hit,
   output logic [3:0]       rsp_slot_used,
   output logic             rsp_name_too_long,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_interval_ms
);

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic [31:0]       addr_ff, addr_in;
   logic [31:0]       now_ff, now_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic [SLOT_W-1:0] best_ff, best_in;
   logic [31:0]       best_time_ff, best_time_in;
   logic [31:0]       elapsed_ff, elapsed_in;
   logic              res_notify_ff, res_notify_in;
   logic              res_hit_ff, res_hit_in;
   logic [31:0]       interval_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_notify_ff, rsp_was_hit_ff, rsp_too_long_ff;
   logic [3:0]        rsp_slot_ff;
   logic              rsp_load;

   logic              req_acc;
   logic              buf_we;
   logic [7:0]        buf_rdata;
   logic [31:0]       op_a, op_b;
   alu_out_type       alu;
   store_ctl_type     ctl;
   store_rd_type      rd;

   enrl_alu u_alu (
      .op_a (op_a),
      .op_b (op_b),
      .res  (alu)
   );

   enrl_name_buf u_name_buf (
      .clock (clock),
      .we    (buf_we),
      .waddr (len_ff),
      .wdata (req_name_char),
      .raddr (k_ff),
      .rdata (buf_rdata)
   );

   enrl_store u_store (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .rd    (rd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      ovf_in        = ovf_ff;
      addr_in       = addr_ff;
      now_in        = now_ff;
      slot_in       = slot_ff;
      k_in          = k_ff;
      best_in       = best_ff;
      best_time_in  = best_time_ff;
      elapsed_in    = elapsed_ff;
      res_notify_in = res_notify_ff;
      res_hit_in    = res_hit_ff;
      rsp_load      = 1'b0;
      buf_we        = 1'b0;
      op_a          = '0;
      op_b          = '0;

      ctl            = '0;
      ctl.rd_slot    = slot_ff;
      ctl.name_raddr = {slot_ff, k_ff};
      ctl.name_waddr = {best_ff, k_ff};
      ctl.name_wdata = buf_rdata;
      ctl.meta_addr  = addr_ff;
      ctl.meta_stamp = now_ff;
      ctl.meta_len   = len_ff;
      ctl.meta_slot  = best_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_name_char != 8'd0) begin
                  if (len_ff < LEN_MAX) begin
                     buf_we = 1'b1;
                     len_in = len_ff + LEN_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  addr_in  = req_client_addr;
                  now_in   = req_now_ms;
                  slot_in  = '0;
                  // an overlong name never matches: go straight to replacement
                  state_in = ovf_ff ? S_OLDEST : S_MATCH;
               end
            end
         end
         S_MATCH: begin
            op_a = rd.addr;
            op_b = addr_ff;
            if (alu.eq && (rd.len == len_ff)) begin
               k_in     = '0;
               state_in = (len_ff == '0) ? S_ELAPSED : S_RD;
            end else if (slot_ff == SLOT_LAST) begin
               slot_in  = '0;
               state_in = S_OLDEST;
            end else begin
               slot_in  = slot_ff + SLOT_W'(1);
            end
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            op_a = {24'd0, buf_rdata};
            op_b = {24'd0, rd.name_byte};
            if (!alu.eq) begin
               if (slot_ff == SLOT_LAST) begin
                  slot_in  = '0;
                  state_in = S_OLDEST;
               end else begin
                  slot_in  = slot_ff + SLOT_W'(1);
                  state_in = S_MATCH;
               end
            end else if (k_ff == len_ff - LEN_W'(1)) begin
               state_in = S_ELAPSED;
            end else begin
               k_in     = k_ff + LEN_W'(1);
               state_in = S_RD;
            end
         end
         S_ELAPSED: begin
            op_a       = now_ff;
            op_b       = rd.stamp;
            elapsed_in = alu.diff;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            op_a          = elapsed_ff;
            op_b          = interval_ff;
            res_notify_in = !alu.lt;
            res_hit_in    = 1'b1;
            best_in       = slot_ff;
            // refresh the timestamp only when notifying
            ctl.meta_we   = !alu.lt;
            ctl.meta_slot = slot_ff;
            state_in      = S_DONE;
         end
         S_OLDEST: begin
            op_a = rd.stamp;
            op_b = best_time_ff;
            if ((slot_ff == '0) || alu.lt) begin
               best_in      = slot_ff;
               best_time_in = rd.stamp;
            end
            if (slot_ff == SLOT_LAST) begin
               k_in     = '0;
               state_in = (len_ff == '0) ? S_META : S_COPY_RD;
            end else begin
               slot_in  = slot_ff + SLOT_W'(1);
            end
         end
         S_COPY_RD: begin
            state_in = S_COPY_WR;
         end
         S_COPY_WR: begin
            ctl.name_we = 1'b1;
            if (k_ff == len_ff - LEN_W'(1)) begin
               state_in = S_META;
            end else begin
               k_in     = k_ff + LEN_W'(1);
               state_in = S_COPY_RD;
            end
         end
         S_META: begin
            ctl.meta_we   = 1'b1;
            res_notify_in = 1'b1;
            res_hit_in    = 1'b0;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               len_in   = '0;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         interval_ff  <= INTERVAL_RESET;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            interval_ff <= csr_interval_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      now_ff        <= now_in;
      slot_ff       <= slot_in;
      k_ff          <= k_in;
      best_ff       <= best_in;
      best_time_ff  <= best_time_in;
      elapsed_ff    <= elapsed_in;
      res_notify_ff <= res_notify_in;
      res_hit_ff    <= res_hit_in;
      if (rsp_load) begin
         rsp_notify_ff   <= res_notify_ff;
         rsp_was_hit_ff  <= res_hit_ff;
         rsp_slot_ff     <= slot_code(best_ff);
         rsp_too_long_ff <= ovf_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_notify        = rsp_notify_ff;
   assign rsp_was_hit       = rsp_was_hit_ff;
   assign rsp_slot_used     = rsp_slot_ff;
   assign rsp_name_too_long = rsp_too_long_ff;

endmodule
`default_nettype wire
